// File: rtl/deque_with_value_search_macros.svh
// assertion macros for the deque checker
// expects clk and rst_n in scope at the point of use
`ifndef DEQUE_WITH_VALUE_SEARCH_MACROS_SVH
`define DEQUE_WITH_VALUE_SEARCH_MACROS_SVH

// property that must hold at every edge out of reset
`define DQVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence required in the cycle after the trigger
`define DQVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dqvs_pkg.sv
// shared types and constants of the deque with value search
// no dependencies
`timescale 1ns / 1ps

package dqvs_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int COUNT_W   = 7;

  // command codes
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_SEARCH     = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [31:0]   found_value;
    logic [COUNT_W-1:0]   count;
  } out_t;

endpackage

// File: rtl/dqvs_mem.sv
// entry store of the deque: one write port, one registered read port
// depends on dqvs_pkg for the default depth
`timescale 1ns / 1ps

module dqvs_mem #(
  parameter int DEPTH = dqvs_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [31:0]              rdata
);

  logic [31:0] mem_r [DEPTH];
  logic [31:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dqvs_ctrl.sv
// deque control: pointers, count, command decode and the search walk
// depends on dqvs_pkg; drives the entry store in dqvs_mem
`timescale 1ns / 1ps

module dqvs_ctrl #(
  parameter int DEPTH = dqvs_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  dqvs_pkg::in_t            in_data,
  output logic                     out_valid,
  output dqvs_pkg::out_t           out_data,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [31:0]              mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [31:0]              mem_rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dqvs_pkg::state_t  state_r, state_nxt;
  logic [PTR_W-1:0]  front_r, front_nxt;
  logic [PTR_W-1:0]  back_r, back_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [PTR_W-1:0]  p_r, p_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  dqvs_pkg::out_t    out_r, out_nxt;

  logic [PTR_W-1:0]  back_inc, front_inc, back_dec, front_dec, p_inc;
  logic              full, empty, hit;
  logic [CNT_W+dqvs_pkg::COUNT_W-1:0] cnt_ext;

  // ring pointer steps with explicit wrap
  assign back_inc  = (back_r == LAST_PTR) ? '0 : back_r + PTR_W'(1);
  assign front_inc = (front_r == LAST_PTR) ? '0 : front_r + PTR_W'(1);
  assign p_inc     = (p_r == LAST_PTR) ? '0 : p_r + PTR_W'(1);
  assign back_dec  = (back_r == '0) ? LAST_PTR : back_r - PTR_W'(1);
  assign front_dec = (front_r == '0) ? LAST_PTR : front_r - PTR_W'(1);

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign hit   = pend_r && (mem_rdata == key_r);

  // count as reported, masked to the result field
  assign cnt_ext = {{dqvs_pkg::COUNT_W{1'b0}}, cnt_nxt};

  // next state, pointer updates and result
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    p_nxt         = p_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = back_r;
    mem_wdata     = in_data.value;
    mem_re        = 1'b0;
    mem_raddr     = p_r;

    case (state_r)
      dqvs_pkg::S_IDLE: begin
        if (start) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = dqvs_pkg::ST_OK;
          out_nxt.found_value = '0;
          case (in_data.cmd)
            dqvs_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                out_nxt.status = dqvs_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = back_r;
                back_nxt  = back_inc;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            dqvs_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                out_nxt.status = dqvs_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                front_nxt = front_dec;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            dqvs_pkg::CMD_POP_FRONT: begin
              if (empty) begin
                out_nxt.status = dqvs_pkg::ST_EMPTY;
              end else begin
                front_nxt = front_inc;
                cnt_nxt   = cnt_r - CNT_W'(1);
              end
            end
            dqvs_pkg::CMD_POP_BACK: begin
              if (empty) begin
                out_nxt.status = dqvs_pkg::ST_EMPTY;
              end else begin
                back_nxt = back_dec;
                cnt_nxt  = cnt_r - CNT_W'(1);
              end
            end
            dqvs_pkg::CMD_SEARCH: begin
              if (empty) begin
                out_nxt.status = dqvs_pkg::ST_NOTFOUND;
              end else begin
                // walk from the front, result comes at the end of the walk
                out_valid_nxt = 1'b0;
                state_nxt     = dqvs_pkg::S_SEARCH;
                key_nxt       = in_data.value;
                p_nxt         = front_r;
                idx_nxt       = '0;
              end
            end
            default: begin
            end
          endcase
          out_nxt.count = cnt_ext[dqvs_pkg::COUNT_W-1:0];
        end
      end
      dqvs_pkg::S_SEARCH: begin
        if (hit) begin
          // match on the entry read last cycle
          state_nxt           = dqvs_pkg::S_IDLE;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = dqvs_pkg::ST_OK;
          out_nxt.found_value = key_r;
          out_nxt.count       = cnt_ext[dqvs_pkg::COUNT_W-1:0];
        end else if (idx_r == cnt_r) begin
          // every held entry compared without a match
          state_nxt           = dqvs_pkg::S_IDLE;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = dqvs_pkg::ST_NOTFOUND;
          out_nxt.found_value = '0;
          out_nxt.count       = cnt_ext[dqvs_pkg::COUNT_W-1:0];
        end else begin
          // issue the read of the next held entry
          mem_re    = 1'b1;
          mem_raddr = p_r;
          p_nxt     = p_inc;
          idx_nxt   = idx_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt = dqvs_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqvs_pkg::S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    p_r   <= p_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != dqvs_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/deque_with_value_search.sv
// Pushes and pops: result strobe in the cycle after the transfer, one command per cycle.
// Search: walks held entries front to back, one memory read per cycle, and answers
// at the first match or after the last held entry, busy meanwhile.
// A search on an empty deque answers in the cycle after the transfer. Results cannot be stalled.
// Reset (synchronous, active low) clears pointers and count; the entry store is
// not cleared and is only read where written.
`timescale 1ns / 1ps

module deque_with_value_search #(
  parameter int DEPTH = dqvs_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dqvs_pkg::in_t  in_data,
  output logic           out_valid,
  output dqvs_pkg::out_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);

  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata, mem_rdata;

  // command decode, pointers and search walk
  dqvs_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // entry store
  dqvs_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: rtl/dqvs_chk.sv
// port-level checks of the deque, attached to the top level by bind
// depends on dqvs_pkg and deque_with_value_search_macros.svh
`timescale 1ns / 1ps
`include "deque_with_value_search_macros.svh"

module dqvs_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input dqvs_pkg::in_t  in_data,
  input logic           out_valid,
  input dqvs_pkg::out_t out_data
);

  logic xfer, non_search, fail_res, empty_res;

  assign xfer       = start && !busy;
  assign non_search = (in_data.cmd != dqvs_pkg::CMD_SEARCH);
  assign fail_res   = out_valid && (out_data.status != dqvs_pkg::ST_OK);
  assign empty_res  = out_valid && (out_data.status == dqvs_pkg::ST_EMPTY);

  // a transfer other than a search answers in the next cycle and does not hold the port
  `DQVS_ASSERT_NEXT(a_direct_result, xfer && non_search, out_valid && !busy, "missing result")
  // a search transfer either answers at once or keeps the block busy
  `DQVS_ASSERT_NEXT(a_search_progress, xfer && !non_search, out_valid || busy, "search lost")
  // a result only follows a transfer or a running search
  `DQVS_ASSERT(a_no_spurious, out_valid |-> $past(xfer || busy), "unexpected result")
  // only a found search carries a value
  `DQVS_ASSERT(a_value_zero, fail_res |-> (out_data.found_value == '0), "value on failure")
  // an empty pop leaves nothing held
  `DQVS_ASSERT(a_empty_count, empty_res |-> (out_data.count == '0), "count on empty pop")

endmodule

bind deque_with_value_search dqvs_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: verif/tb_deque_with_value_search.sv
// testbench for deque_with_value_search: directed table, then random command sequences
// checks each result against its pinned row or a deque predictor; depends on dqvs_pkg, rtl
`timescale 1ns / 1ps

module tb_deque_with_value_search;
  import dqvs_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int IDLE_LIMIT = 1000;

  // command codes with no operation behind them
  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

  typedef struct {
    in_t  item;
    logic pin;
    out_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  // pinned expectation travels with the command transfer
  logic row_pin;
  out_t row_exp;

  // predictor state
  logic signed [31:0] ring_mem [DEPTH];
  int                 head_idx;
  int                 tail_idx;
  int                 held;

  out_t     pending_results [$];
  dir_row_t dir_rows [$];
  int       fail_count;
  int       idle_cycles;
  int       idle_pct;
  int       items_sent;

  deque_with_value_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // deque behaviour for one command; updates the predictor state
  function automatic out_t deque_apply(in_t c);
    out_t r;
    int   p;
    logic hit;
    r.status      = ST_OK;
    r.found_value = '0;
    hit           = 1'b0;
    p             = head_idx;
    case (c.cmd)
      CMD_PUSH_BACK: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[tail_idx] = c.value;
          tail_idx = (tail_idx + 1) % DEPTH;
          held++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          ring_mem[head_idx] = c.value;
          held++;
        end
      end
      CMD_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % DEPTH;
          held--;
        end
      end
      CMD_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
          held--;
        end
      end
      CMD_SEARCH: begin
        // scan held entries front to back
        for (int i = 0; i < held; i++) begin
          if (ring_mem[p] == c.value) hit = 1'b1;
          p = (p + 1) % DEPTH;
        end
        if (hit) r.found_value = c.value;
        else r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.count = held[COUNT_W-1:0];
    return r;
  endfunction

  // result check, then prediction for the command taken at this edge
  always @(posedge clk) begin
    out_t exp_res;
    out_t pred;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: status %0d found_value %0d count %0d",
                 out_data.status, out_data.found_value, out_data.count);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_data.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
            fail_count++;
          end
          if (out_data.found_value !== exp_res.found_value) begin
            $error("found_value: expected %0d, got %0d",
                   exp_res.found_value, out_data.found_value);
            fail_count++;
          end
          if (out_data.count !== exp_res.count) begin
            $error("count: expected %0d, got %0d", exp_res.count, out_data.count);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pred = deque_apply(in_data);
        pending_results.push_back(row_pin ? row_exp : pred);
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic dir_row_t mk_row(logic [2:0] cmd, logic signed [31:0] val, logic pin,
                                      logic [1:0] st, logic signed [31:0] fv, int cnt);
    dir_row_t r;
    r.item.cmd          = cmd;
    r.item.value        = val;
    r.pin               = pin;
    r.res.status        = st;
    r.res.found_value   = fv;
    r.res.count         = cnt[COUNT_W-1:0];
    return r;
  endfunction

  // mostly wide random values, some small ones for duplicates, some extremes
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(9))
      0, 1: return $urandom_range(7);
      2: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // a value that is currently held, where there is one
  function automatic logic signed [31:0] held_value();
    if (held == 0) return rand_value();
    return ring_mem[(head_idx + $urandom_range(held - 1)) % DEPTH];
  endfunction

  // one command transfer, with random idle cycles ahead of it
  task automatic issue(in_t item, logic pin, out_t res);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    row_pin <= pin;
    row_exp <= res;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic issue_cmd(logic [2:0] cmd, logic signed [31:0] val);
    in_t item;
    item.cmd   = cmd;
    item.value = val;
    issue(item, 1'b0, '0);
  endtask

  // hold the sender off until every expected result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // random sequences: fill past full, drain past empty, or mixed single commands
  task automatic run_phase(int n_items, int pct);
    int target;
    int k;
    idle_pct = pct;
    target   = items_sent + n_items;
    while (items_sent < target) begin
      case ($urandom_range(19))
        0: begin
          k = DEPTH - held + $urandom_range(1, 3);
          repeat (k) begin
            issue_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_value());
          end
        end
        1: begin
          k = held + $urandom_range(1, 2);
          repeat (k) begin
            issue_cmd($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, rand_value());
          end
        end
        default: begin
          k = $urandom_range(99);
          if (k < 18) issue_cmd(CMD_PUSH_BACK, rand_value());
          else if (k < 35) issue_cmd(CMD_PUSH_FRONT, rand_value());
          else if (k < 47) issue_cmd(CMD_POP_FRONT, rand_value());
          else if (k < 60) issue_cmd(CMD_POP_BACK, rand_value());
          else if (k < 85) issue_cmd(CMD_SEARCH, held_value());
          else if (k < 95) issue_cmd(CMD_SEARCH, rand_value());
          else issue_cmd(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), rand_value());
        end
      endcase
    end
    drain_results();
  endtask

  // stimulus
  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    row_pin    = 1'b0;
    row_exp    = '0;
    head_idx   = 0;
    tail_idx   = 0;
    held       = 0;
    fail_count = 0;
    idle_pct   = 0;
    items_sent = 0;

    // directed table: empty pops and search, value zero, extremes, unused codes
    dir_rows.push_back(mk_row(CMD_POP_FRONT,  32'sd0,          1'b1, ST_EMPTY,    32'sd0, 0));
    dir_rows.push_back(mk_row(CMD_POP_BACK,   -32'sd1,         1'b1, ST_EMPTY,    32'sd0, 0));
    dir_rows.push_back(mk_row(CMD_SEARCH,     32'sd0,          1'b1, ST_NOTFOUND, 32'sd0, 0));
    dir_rows.push_back(mk_row(CMD_PUSH_BACK,  32'sd0,          1'b1, ST_OK,       32'sd0, 1));
    dir_rows.push_back(mk_row(CMD_SEARCH,     32'sd0,          1'b1, ST_OK,       32'sd0, 1));
    dir_rows.push_back(mk_row(CMD_PUSH_FRONT, 32'sh7fff_ffff,  1'b1, ST_OK,       32'sd0, 2));
    dir_rows.push_back(mk_row(CMD_PUSH_BACK,  32'sh8000_0000,  1'b1, ST_OK,       32'sd0, 3));
    dir_rows.push_back(mk_row(CMD_SEARCH,     32'sh8000_0000,  1'b1, ST_OK,
                              32'sh8000_0000, 3));
    dir_rows.push_back(mk_row(CMD_SEARCH,     32'sh7fff_ffff,  1'b1, ST_OK,
                              32'sh7fff_ffff, 3));
    dir_rows.push_back(mk_row(CMD_SEARCH,     32'sh0001_2345,  1'b1, ST_NOTFOUND, 32'sd0, 3));
    dir_rows.push_back(mk_row(CMD_UNUSED_LO,  32'sh7fff_ffff,  1'b1, ST_OK,       32'sd0, 3));
    dir_rows.push_back(mk_row(CMD_UNUSED_MID, -32'sd1,         1'b1, ST_OK,       32'sd0, 3));
    dir_rows.push_back(mk_row(CMD_UNUSED_HI,  32'sh8000_0000,  1'b1, ST_OK,       32'sd0, 3));
    dir_rows.push_back(mk_row(CMD_PUSH_FRONT, -32'sd1,         1'b0, ST_OK,       32'sd0, 0));
    dir_rows.push_back(mk_row(CMD_SEARCH,     -32'sd1,         1'b0, ST_OK,       32'sd0, 0));
    dir_rows.push_back(mk_row(CMD_POP_FRONT,  32'sd0,          1'b0, ST_OK,       32'sd0, 0));
    dir_rows.push_back(mk_row(CMD_POP_FRONT,  32'sd0,          1'b1, ST_OK,       32'sd0, 2));
    dir_rows.push_back(mk_row(CMD_SEARCH,     32'sh7fff_ffff,  1'b1, ST_NOTFOUND, 32'sd0, 2));
    dir_rows.push_back(mk_row(CMD_POP_BACK,   32'sd0,          1'b1, ST_OK,       32'sd0, 1));
    dir_rows.push_back(mk_row(CMD_SEARCH,     32'sh8000_0000,  1'b1, ST_NOTFOUND, 32'sd0, 1));
    dir_rows.push_back(mk_row(CMD_POP_BACK,   32'sd0,          1'b1, ST_OK,       32'sd0, 0));
    dir_rows.push_back(mk_row(CMD_POP_BACK,   32'sd0,          1'b1, ST_EMPTY,    32'sd0, 0));
    dir_rows.push_back(mk_row(CMD_SEARCH,     32'sd0,          1'b1, ST_NOTFOUND, 32'sd0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].item, dir_rows[i].pin, dir_rows[i].res);
    end
    drain_results();

    // random part under different sender idling
    run_phase(140, 0);
    run_phase(130, 79);
    run_phase(130, 37);

    // settle: no further results may appear
    repeat (DEPTH + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
